@@ rtl/core/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sinh Taylor series block.
// ----------------------------------------------------------------------------
package sts_pkg;

    // field widths
    localparam int X_W       = 31;
    localparam int CNT_W     = 5;
    localparam int FRAC_BITS = 30;
    localparam int PROD_W    = 2 * X_W;

    // series length limit and derived counter width
    localparam int MAX_TERMS = 31;
    localparam int N_W       = $clog2(MAX_TERMS + 1);

    // register reset value
    localparam logic [CNT_W-1:0] TERM_COUNT_RESET = CNT_W'(10);

    // argument range, Q1.30
    localparam logic [X_W-1:0] X_LOW   = X_W'(107374183);
    localparam logic [X_W-1:0] X_HIGH  = X_W'(1073741824);
    localparam logic [X_W-1:0] SUM_MAX = {X_W{1'b1}};

    // divisor d = (2n+2)(2n+3), stepped by first and second differences
    localparam int D_W        = $clog2(4 * MAX_TERMS * MAX_TERMS + 10 * MAX_TERMS + 6 + 1);
    localparam int S_W        = $clog2(8 * MAX_TERMS + 14 + 1);
    localparam logic [D_W-1:0] D_INIT    = D_W'(6);
    localparam logic [S_W-1:0] STEP_INIT = S_W'(14);
    localparam logic [S_W-1:0] STEP_INC  = S_W'(8);

    // radix-2 divider, several quotient bits per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = (X_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QUO_W      = DIV_CYCLES * DIV_BITS;
    localparam int DIVC_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture argument, init term, sum, divisor
        logic mul;       // register a product
        logic mul_sq;    // product operands are x and x
        logic x2_ld;     // capture x*x >> 30
        logic div_load;  // load dividend from product
        logic div_step;  // one group of quotient bits
        logic acc;       // take quotient as new term, add to sum
        logic store;     // write the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_err;    // argument on the input port is out of range
    } t_stat;

endpackage

@@ rtl/core/sts_dpath.sv @@
// ----------------------------------------------------------------------------
// sts_dpath
// Datapath: shared multiplier, multi-bit restoring divider, series sum.
// ----------------------------------------------------------------------------
module sts_dpath (
    input  logic                    i_clk,
    input  logic [sts_pkg::X_W-1:0] i_arg_x,
    input  sts_pkg::t_cmd           i_cmd,
    output sts_pkg::t_stat          o_stat,
    output logic [sts_pkg::X_W-1:0] o_sinh_sum,
    output logic                    o_range_error
);
    import sts_pkg::*;

    logic [X_W-1:0]    r_x, r_x2, r_term, r_sum;
    logic              r_err;
    logic [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [D_W-1:0]    r_rem, n_rem;
    logic [D_W-1:0]    r_d;
    logic [S_W-1:0]    r_step;
    logic [X_W-1:0]    r_out_sum;
    logic              r_out_err;

    logic [X_W-1:0]    mul_a, mul_b;
    logic [X_W:0]      sum_ext;
    logic [X_W-1:0]    sum_sat;

    // range check on the incoming argument
    assign o_stat.in_err = (i_arg_x < X_LOW) || (i_arg_x > X_HIGH);

    // shared multiplier operand select
    assign mul_a = i_cmd.mul_sq ? r_x : r_term;
    assign mul_b = i_cmd.mul_sq ? r_x : r_x2;

    // DIV_BITS restoring steps on a narrow remainder
    always_comb begin
        logic [D_W:0] rem_s;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            rem_s = {n_rem, n_quo[QUO_W-1]};
            n_quo = {n_quo[QUO_W-2:0], 1'b0};
            if (rem_s >= {1'b0, r_d}) begin
                rem_s    = rem_s - {1'b0, r_d};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_s[D_W-1:0];
        end
    end

    // saturating accumulate of the new term
    assign sum_ext = {1'b0, r_sum} + {1'b0, r_quo[X_W-1:0]};
    assign sum_sat = sum_ext[X_W] ? SUM_MAX : sum_ext[X_W-1:0];

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_arg_x;
            r_term <= i_arg_x;
            r_sum  <= i_arg_x;
            r_err  <= o_stat.in_err;
            r_d    <= D_INIT;
            r_step <= STEP_INIT;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_cmd.x2_ld) begin
            r_x2 <= r_prod[FRAC_BITS +: X_W];
        end
        if (i_cmd.div_load) begin
            r_quo <= QUO_W'(r_prod[FRAC_BITS +: X_W]);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.acc) begin
            r_term <= r_quo[X_W-1:0];
            r_sum  <= sum_sat;
            r_d    <= r_d + D_W'(r_step);
            r_step <= r_step + STEP_INC;
        end
        if (i_cmd.store) begin
            r_out_sum <= r_err ? '0 : r_sum;
            r_out_err <= r_err;
        end
    end

    assign o_sinh_sum    = r_out_sum;
    assign o_range_error = r_out_err;

endmodule

@@ rtl/core/sts_ctrl.sv @@
// ----------------------------------------------------------------------------
// sts_ctrl
// Controller: term sequencing, divider cycle count, handshakes, register.
// ----------------------------------------------------------------------------
module sts_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sts_pkg::CNT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  sts_pkg::t_stat            i_stat,
    output sts_pkg::t_cmd             o_cmd
);
    import sts_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQ   = 8'b0000_0010,
        S_X2   = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_DIVL = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_term_count;
    logic [N_W-1:0]    r_left, n_left;
    logic [DIVC_W-1:0] r_div_cnt, n_div_cnt;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer;
    logic              slot_free;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    if (int'(r_term_count) > MAX_TERMS) begin
                        n_left = N_W'(MAX_TERMS);
                    end else begin
                        n_left = N_W'(r_term_count);
                    end
                    n_state = i_stat.in_err ? S_DONE : S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul    = 1'b1;
                o_cmd.mul_sq = 1'b1;
                n_state      = S_X2;
            end
            S_X2: begin
                o_cmd.x2_ld = 1'b1;
                n_state     = (r_left == '0) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVL;
            end
            S_DIVL: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIVC_W'(1);
                if (r_div_cnt == DIVC_W'(DIV_CYCLES - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_left    = r_left - N_W'(1);
                n_state   = (r_left == N_W'(1)) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on store, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.store) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_COUNT_RESET;
            r_left       <= '0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_term_count <= i_cfg_data;
            end
        end
    end

    // out-of-range argument skips the series
    a_err_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_stat.in_err) |=> (r_state == S_DONE))
        else $error("out-of-range argument did not go straight to result");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store |-> slot_free)
        else $error("result stored over a pending result");

    // a term is only computed while terms remain
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_left != '0))
        else $error("term multiply with no terms left");

    // divider runs its full cycle count before accumulate
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_DIV
            && $past(r_div_cnt) == DIVC_W'(DIV_CYCLES - 1)))
        else $error("accumulate without a complete division");

endmodule

@@ rtl/core/sinh_taylor_series.sv @@
// ----------------------------------------------------------------------------
// sinh_taylor_series
// Taylor-series hyperbolic sine of an unsigned Q1.30 argument.
// ----------------------------------------------------------------------------
// One argument is worked on at a time. After the input transfer, x*x is
// formed once on the shared 31x31 multiplier; then, for each of N terms (N
// being the term count register, saturated at MAX_TERMS), the block
// multiplies on the same multiplier, loads the dividend, divides (8 quotient
// bits a cycle) and accumulates. An argument outside 0.1 to 1.0 skips the
// series and returns range_error with a zero sum. The result sits in an
// output register; a new argument is taken as soon as the result is written
// there, even if it has not been transferred out. The term count register
// resets to 10 and is written only while the block is idle.
// ----------------------------------------------------------------------------
module sinh_taylor_series (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [sts_pkg::X_W-1:0]   i_arg_x,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [sts_pkg::X_W-1:0]   o_sinh_sum,
    output logic                      o_range_error,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sts_pkg::CNT_W-1:0] i_cfg_data
);
    import sts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing and handshakes
    sts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic
    sts_dpath u_dpath (
        .i_clk         (i_clk),
        .i_arg_x       (i_arg_x),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_sinh_sum    (o_sinh_sum),
        .o_range_error (o_range_error)
    );

endmodule

@@ test/tb_sinh_taylor_series.sv @@
// ----------------------------------------------------------------------------
// tb_sinh_taylor_series
// Self-checking bench for the sinh Taylor series block. A queue of arguments,
// term count writes and drain points feeds a negedge driver; a posedge monitor
// predicts each result from the argument and the current term count and
// checks every output transfer in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_sinh_taylor_series;

    import sts_pkg::*;

    typedef enum logic [1:0] {
        STIM_ARG,    // argument transfer
        STIM_CFG,    // term count write, issued once the block is idle
        STIM_DRAIN   // hold off until every result is back
    } stim_kind_e;

    typedef struct {
        stim_kind_e       kind;
        logic [X_W-1:0]   arg;
        logic [CNT_W-1:0] count;
    } stim_t;

    typedef struct {
        logic [X_W-1:0] sum;
        logic           err;
    } sinh_result_t;

    localparam int RANDOM_ARGS = 1300;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [X_W-1:0]   i_arg_x = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [X_W-1:0]   o_sinh_sum;
    logic             o_range_error;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;

    stim_t            stim_queue[$];
    sinh_result_t     sinh_expect_q[$];
    stim_t            head;
    logic [CNT_W-1:0] cur_term_count = TERM_COUNT_RESET;

    // handshake flags: set at posedge by the monitor, cleared at negedge
    bit               arg_taken = 0;
    bit               cfg_taken = 0;
    bit               out_taken = 0;
    bit               arg_busy = 0;
    bit               cfg_busy = 0;
    logic [X_W-1:0]   arg_next = '0;
    logic [CNT_W-1:0] cfg_next = '0;
    int               send_gap = 0;
    int               out_stall = 0;
    int               tx_quiet = 0;
    int               rx_quiet = 0;
    int               error_count = 0;

    sinh_taylor_series dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_arg_x       (i_arg_x),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sinh_sum    (o_sinh_sum),
        .o_range_error (o_range_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // series value of sinh(x) with truncating Q1.30 arithmetic
    function automatic sinh_result_t sinh_series(input logic [X_W-1:0] x,
                                                 input logic [CNT_W-1:0] count);
        sinh_result_t res;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  divisor;
        int           terms;
        res.sum = '0;
        res.err = 1'b1;
        if (x < X_LOW || x > X_HIGH)
            return res;
        terms = (int'(count) > MAX_TERMS) ? MAX_TERMS : int'(count);
        x2    = (64'(x) * 64'(x)) >> FRAC_BITS;
        term  = 64'(x);
        sum   = 64'(x);
        for (int n = 0; n < terms; n++) begin
            divisor = 64'(4 * n * n + 10 * n + 6);
            term    = ((term * x2) >> FRAC_BITS) / divisor;
            sum     = sum + term;
            if (sum > 64'(SUM_MAX))
                sum = 64'(SUM_MAX);
        end
        res.sum = sum[X_W-1:0];
        res.err = 1'b0;
        return res;
    endfunction

    // idle length: mostly none or short, a few long, now and then a quiet run
    function automatic int pick_idle(inout int quiet);
        int roll;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 199);
        if (roll == 0) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 110)
            return 0;
        if (roll < 185)
            return $urandom_range(1, 3);
        return $urandom_range(15, 80);
    endfunction

    function automatic logic [X_W-1:0] random_arg();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return X_W'($urandom_range(int'(X_LOW), int'(X_HIGH)));
        case (roll)
            80, 81:  return X_LOW - 1'b1;
            82, 83:  return X_LOW;
            84, 85:  return X_HIGH;
            86, 87:  return X_HIGH + 1'b1;
            default: return X_W'($urandom());
        endcase
    endfunction

    task automatic add_arg(input logic [X_W-1:0] x);
        stim_t s;
        s.kind  = STIM_ARG;
        s.arg   = x;
        s.count = '0;
        stim_queue.push_back(s);
    endtask

    task automatic add_cfg(input logic [CNT_W-1:0] count);
        stim_t s;
        s.kind  = STIM_CFG;
        s.arg   = '0;
        s.count = count;
        stim_queue.push_back(s);
    endtask

    task automatic add_drain();
        stim_t s;
        s.kind  = STIM_DRAIN;
        s.arg   = '0;
        s.count = '0;
        stim_queue.push_back(s);
    endtask

    // driver: launches queued transfers at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (arg_taken) begin
                arg_taken = 0;
                arg_busy  = 0;
                send_gap  = pick_idle(tx_quiet);
            end
            if (cfg_taken) begin
                cfg_taken = 0;
                cfg_busy  = 0;
            end
            if (!arg_busy && !cfg_busy && stim_queue.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    head = stim_queue[0];
                    case (head.kind)
                        STIM_ARG: begin
                            stim_queue.delete(0);
                            arg_busy = 1;
                            arg_next = head.arg;
                        end
                        STIM_CFG: begin
                            if (sinh_expect_q.size() == 0) begin
                                stim_queue.delete(0);
                                cfg_busy = 1;
                                cfg_next = head.count;
                            end
                        end
                        default: begin
                            if (sinh_expect_q.size() == 0)
                                stim_queue.delete(0);
                        end
                    endcase
                end
            end
            i_in_valid  <= arg_busy;
            i_arg_x     <= arg_next;
            i_cfg_valid <= cfg_busy;
            i_cfg_data  <= cfg_next;
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                out_taken = 0;
                out_stall = pick_idle(rx_quiet);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on argument transfer, check on result transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sinh_expect_q.push_back(sinh_series(i_arg_x, cur_term_count));
                arg_taken = 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cur_term_count = i_cfg_data;
                cfg_taken      = 1;
            end
            if (o_out_valid && i_out_ready) begin
                out_taken = 1;
                if (sinh_expect_q.size() == 0) begin
                    $error("result with none expected: sinh_sum %0d range_error %0d",
                           o_sinh_sum, o_range_error);
                    error_count++;
                end else begin
                    if (o_sinh_sum !== sinh_expect_q[0].sum) begin
                        $error("sinh_sum mismatch: expected %0d, actual %0d",
                               sinh_expect_q[0].sum, o_sinh_sum);
                        error_count++;
                    end
                    if (o_range_error !== sinh_expect_q[0].err) begin
                        $error("range_error mismatch: expected %0d, actual %0d",
                               sinh_expect_q[0].err, o_range_error);
                        error_count++;
                    end
                    sinh_expect_q.delete(0);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int               made;
        int               phase_len;
        int               roll;
        logic [CNT_W-1:0] count;

        // directed: range edges at the reset term count of 10
        add_arg(X_LOW - 1'b1);
        add_arg(X_LOW);
        add_arg(X_HIGH);
        add_arg(X_HIGH + 1'b1);
        add_arg('0);
        add_arg({X_W{1'b1}});
        add_arg(X_W'(32'h2000_0000));
        add_arg(X_W'(32'h3FFF_FFFF));
        // zero term count: sum is x itself
        add_cfg('0);
        add_arg(X_LOW);
        add_arg(X_HIGH);
        add_arg(X_W'(32'h1555_5555));
        add_arg(X_HIGH + 1'b1);
        // longest series
        add_cfg({CNT_W{1'b1}});
        add_arg(X_LOW);
        add_arg(X_HIGH);
        add_arg(X_W'(32'h2AAA_AAAA));
        add_arg({X_W{1'b1}});
        add_drain();

        // random phases, each with its own term count
        made = 0;
        while (made < RANDOM_ARGS) begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                count = '0;
            else if (roll == 1)
                count = {CNT_W{1'b1}};
            else
                count = CNT_W'($urandom_range(0, 31));
            add_cfg(count);
            phase_len = $urandom_range(40, 120);
            for (int k = 0; k < phase_len && made < RANDOM_ARGS; k++) begin
                add_arg(random_arg());
                made++;
                if ($urandom_range(0, 99) == 0)
                    add_drain();
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_queue.size() > 0 || arg_busy || cfg_busy)
            @(posedge i_clk);
        while (sinh_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
